/* sv/pasc_pkg.sv */
// Shared constants, types and a helper function for the potentiometer conditioning block.
`default_nettype none

package pasc_pkg;

    // Field widths fixed by the interface.
    localparam int ADC_BITS   = 10;
    localparam int ADC_MAX    = (1 << ADC_BITS) - 1;
    localparam int FS_W       = 13;
    localparam int THR_W      = 13;
    localparam int GAIN_W     = 4;
    localparam int PERIOD_W   = 16;
    localparam int POT_W      = ADC_BITS + GAIN_W;
    localparam int PROD_W     = ADC_BITS + FS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default number of samples per channel average.
    localparam int SAMPLES_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_REEL_IN_LOW      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_IN_LOW     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_GAIN       = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD    = CFG_IDX_W'(5);

    // Register reset values.
    localparam logic [ADC_BITS-1:0] REEL_IN_LOW_RST      = ADC_BITS'(140);
    localparam logic [ADC_BITS-1:0] LAYER_IN_LOW_RST     = ADC_BITS'(60);
    localparam logic [FS_W-1:0]     FULL_SCALE_RST       = FS_W'(5000);
    localparam logic [THR_W-1:0]    CHANGE_THRESHOLD_RST = THR_W'(10);
    localparam logic [GAIN_W-1:0]   LAYER_GAIN_RST       = GAIN_W'(1);
    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST    = PERIOD_W'(40);

    // Request type and channel codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic CH_REEL    = 1'b0;
    localparam logic CH_LAYER   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic avg_start;
        logic avg_load;
        logic map_start;
        logic trivial_load;
        logic map_load;
        logic store;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sample_last;
        logic is_layer;
        logic map_trivial;
        logic div_done;
    } status_t;

    // True when two speeds differ by more than the threshold.
    function automatic logic differs(input logic [FS_W-1:0] a, input logic [FS_W-1:0] b,
                                     input logic [THR_W-1:0] thr);
        logic [FS_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return (THR_W'(diff) > thr);
    endfunction

endpackage

`default_nettype wire

/* sv/pot_average_scale_change_detect_core.sv */
// Top level of the two-channel potentiometer averaging, scaling and change detection block.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    s_req_type, s_channel, s_adc_sample
//   m_        out         m_valid/m_ready    m_reel_speed, m_layer_speed, m_*_changed
//   cfg_      in          cfg_wr_en          cfg_index, cfg_data
//
// A tick or a sample that does not complete an average is accepted in idle. A sample that
// completes one holds the input off through the average, map, divider wait (when the map
// is not trivial) and store states, and for the layer until the result is emitted; the
// average is a reciprocal multiplication, the map a 23-step one-bit-per-cycle divider.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished result waits in the output register; only the next result waits for it.
`default_nettype none

module pot_average_scale_change_detect_core #(
    parameter int SAMPLES_PER_AVERAGE = pasc_pkg::SAMPLES_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pasc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pasc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic                                s_channel,
    input  wire logic [pasc_pkg::ADC_BITS-1:0]       s_adc_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [pasc_pkg::FS_W-1:0]                m_reel_speed,
    output logic [pasc_pkg::FS_W-1:0]                m_layer_speed,
    output logic                                     m_reel_changed,
    output logic                                     m_layer_changed
);

    localparam int CNT_W  = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int SUM_W  = pasc_pkg::ADC_BITS + CNT_W;
    localparam int DVD_W  = pasc_pkg::PROD_W;
    localparam int DVS_W  = pasc_pkg::ADC_BITS;

    pasc_pkg::cmd_t    cmd;
    pasc_pkg::status_t status;

    pasc_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    pasc_datapath #(
        .SAMPLES(SAMPLES_PER_AVERAGE),
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W),
        .DVD_W  (DVD_W),
        .DVS_W  (DVS_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_req_type     (s_req_type),
        .s_channel      (s_channel),
        .s_adc_sample   (s_adc_sample),
        .cmd            (cmd),
        .status         (status),
        .m_reel_speed   (m_reel_speed),
        .m_layer_speed  (m_layer_speed),
        .m_reel_changed (m_reel_changed),
        .m_layer_changed(m_layer_changed)
    );

endmodule

`default_nettype wire

/* sv/pasc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module pasc_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 10
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next  = {quo_reg[DVD_W-2:0], fits};
    end

    // Control: a fixed number of steps after each start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift and subtract.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/pasc_datapath.sv */
// Datapath: configuration, sample accumulation, mapping, change detection and output register.
`default_nettype none

module pasc_datapath #(
    parameter int SAMPLES = pasc_pkg::SAMPLES_DEFAULT,
    parameter int SUM_W   = 14,
    parameter int CNT_W   = 4,
    parameter int DVD_W   = 23,
    parameter int DVS_W   = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pasc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pasc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_req_type,
    input  wire logic                                s_channel,
    input  wire logic [pasc_pkg::ADC_BITS-1:0]       s_adc_sample,
    input  wire pasc_pkg::cmd_t                      cmd,
    output pasc_pkg::status_t                        status,
    output logic [pasc_pkg::FS_W-1:0]                m_reel_speed,
    output logic [pasc_pkg::FS_W-1:0]                m_layer_speed,
    output logic                                     m_reel_changed,
    output logic                                     m_layer_changed
);

    localparam int AW = pasc_pkg::ADC_BITS;
    localparam int FW = pasc_pkg::FS_W;
    localparam int PW = pasc_pkg::POT_W;
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SAMPLES - 1);
    localparam logic [PW-1:0]    POT_MAX   = PW'(pasc_pkg::ADC_MAX);
    localparam logic [AW-1:0]    ADC_MAX_V = AW'(pasc_pkg::ADC_MAX);

    // Reciprocal of the sample count; exact for every sum below 2**SUM_W.
    localparam int RCP_SH = SUM_W + CNT_W;
    localparam longint unsigned RCP_M =
        ((64'd1 << RCP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam int RCP_W  = $clog2(RCP_M + 64'd1);
    localparam int AVP_W  = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M_V = RCP_W'(RCP_M);

    // Configuration registers.
    logic [AW-1:0]                    reel_in_low_reg;
    logic [AW-1:0]                    layer_in_low_reg;
    logic [FW-1:0]                    full_scale_reg;
    logic [pasc_pkg::THR_W-1:0]       change_threshold_reg;
    logic [pasc_pkg::GAIN_W-1:0]      layer_gain_reg;
    logic [pasc_pkg::PERIOD_W-1:0]    update_period_reg;

    // Working state.
    logic [SUM_W-1:0]                 reel_sum_reg;
    logic [CNT_W-1:0]                 reel_cnt_reg;
    logic [SUM_W-1:0]                 layer_sum_reg;
    logic [CNT_W-1:0]                 layer_cnt_reg;
    logic [AW-1:0]                    reel_avg_reg;
    logic [FW-1:0]                    reel_speed_reg;
    logic [FW-1:0]                    last_reel_reg;
    logic [FW-1:0]                    last_layer_reg;
    logic [pasc_pkg::PERIOD_W-1:0]    ticks_reg;
    logic                             chan_reg;
    logic [SUM_W-1:0]                 avg_sum_reg;
    logic [PW-1:0]                    pot_reg;
    logic [FW-1:0]                    speed_reg;

    // Output register.
    logic [FW-1:0]                    out_reel_speed_reg;
    logic [FW-1:0]                    out_layer_speed_reg;
    logic                             out_reel_changed_reg;
    logic                             out_layer_changed_reg;

    logic [SUM_W-1:0]                 sel_sum;
    logic [SUM_W-1:0]                 sum_total;
    logic                             sel_last;
    logic [AW-1:0]                    map_low;
    logic                             map_zero;
    logic [AW-1:0]                    map_diff;
    logic [AW-1:0]                    map_den;
    logic [pasc_pkg::PROD_W-1:0]      map_prod;
    logic [AVP_W-1:0]                 avg_prod;
    logic [AW-1:0]                    avg_q;
    logic [PW-1:0]                    layer_mix;
    logic                             div_start;
    logic [DVD_W-1:0]                 div_dividend;
    logic [DVS_W-1:0]                 div_divisor;
    logic                             div_done;
    logic [DVD_W-1:0]                 div_quo;
    logic                             period_done;
    logic                             reel_chg;
    logic                             layer_chg;

    // Accumulation of the transaction's sample into its channel.
    always_comb begin
        sel_sum   = (s_channel == pasc_pkg::CH_LAYER) ? layer_sum_reg : reel_sum_reg;
        sum_total = sel_sum + SUM_W'(s_adc_sample);
        sel_last  = (s_channel == pasc_pkg::CH_LAYER) ? (layer_cnt_reg == CNT_LAST)
                                                      : (reel_cnt_reg == CNT_LAST);
    end

    // Linear map: trivial ends and the scaled product for the divider.
    always_comb begin
        map_low  = (chan_reg == pasc_pkg::CH_LAYER) ? layer_in_low_reg : reel_in_low_reg;
        map_zero = (pot_reg <= PW'(map_low));
        map_diff = pot_reg[AW-1:0] - map_low;
        map_den  = ADC_MAX_V - map_low;
        map_prod = pasc_pkg::PROD_W'(map_diff) * pasc_pkg::PROD_W'(full_scale_reg);
    end

    // Average by reciprocal multiplication, plus the reel contribution for the layer channel.
    always_comb begin
        avg_prod  = AVP_W'(avg_sum_reg) * AVP_W'(RCP_M_V);
        avg_q     = avg_prod[RCP_SH +: AW];
        layer_mix = PW'(avg_q) + PW'(layer_gain_reg) * PW'(reel_avg_reg);
    end

    // Divider operands for the linear map.
    always_comb begin
        div_start    = cmd.map_start;
        div_dividend = DVD_W'(map_prod);
        div_divisor  = DVS_W'(map_den);
    end

    pasc_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    // Change detection against the last reported speeds.
    always_comb begin
        period_done = (ticks_reg >= update_period_reg);
        reel_chg    = period_done &&
                      pasc_pkg::differs(reel_speed_reg, last_reel_reg, change_threshold_reg);
        layer_chg   = period_done &&
                      pasc_pkg::differs(speed_reg, last_layer_reg, change_threshold_reg);
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reel_in_low_reg      <= pasc_pkg::REEL_IN_LOW_RST;
            layer_in_low_reg     <= pasc_pkg::LAYER_IN_LOW_RST;
            full_scale_reg       <= pasc_pkg::FULL_SCALE_RST;
            change_threshold_reg <= pasc_pkg::CHANGE_THRESHOLD_RST;
            layer_gain_reg       <= pasc_pkg::LAYER_GAIN_RST;
            update_period_reg    <= pasc_pkg::UPDATE_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pasc_pkg::REG_REEL_IN_LOW:      reel_in_low_reg      <= cfg_data[AW-1:0];
                pasc_pkg::REG_LAYER_IN_LOW:     layer_in_low_reg     <= cfg_data[AW-1:0];
                pasc_pkg::REG_FULL_SCALE:       full_scale_reg       <= cfg_data[FW-1:0];
                pasc_pkg::REG_CHANGE_THRESHOLD: begin
                    change_threshold_reg <= cfg_data[pasc_pkg::THR_W-1:0];
                end
                pasc_pkg::REG_LAYER_GAIN:       begin
                    layer_gain_reg <= cfg_data[pasc_pkg::GAIN_W-1:0];
                end
                pasc_pkg::REG_UPDATE_PERIOD:    begin
                    update_period_reg <= cfg_data[pasc_pkg::PERIOD_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Sums, counts, tick counter and report history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reel_sum_reg   <= '0;
            reel_cnt_reg   <= '0;
            layer_sum_reg  <= '0;
            layer_cnt_reg  <= '0;
            reel_avg_reg   <= '0;
            reel_speed_reg <= '0;
            last_reel_reg  <= '0;
            last_layer_reg <= '0;
            ticks_reg      <= '0;
            chan_reg       <= pasc_pkg::CH_REEL;
        end else begin
            if (cmd.accept) begin
                if (s_req_type == pasc_pkg::REQ_TICK) begin
                    if (ticks_reg != '1) begin
                        ticks_reg <= ticks_reg + pasc_pkg::PERIOD_W'(1);
                    end
                end else begin
                    chan_reg <= s_channel;
                    if (s_channel == pasc_pkg::CH_LAYER) begin
                        layer_sum_reg <= sel_last ? '0 : sum_total;
                        layer_cnt_reg <= sel_last ? '0 : layer_cnt_reg + CNT_W'(1);
                    end else begin
                        reel_sum_reg <= sel_last ? '0 : sum_total;
                        reel_cnt_reg <= sel_last ? '0 : reel_cnt_reg + CNT_W'(1);
                    end
                end
            end
            if (cmd.avg_load && chan_reg == pasc_pkg::CH_REEL) begin
                reel_avg_reg <= avg_q;
            end
            if (cmd.store && chan_reg == pasc_pkg::CH_REEL) begin
                reel_speed_reg <= speed_reg;
            end
            if (cmd.emit && period_done) begin
                ticks_reg <= '0;
                if (reel_chg) begin
                    last_reel_reg <= reel_speed_reg;
                end
                if (layer_chg) begin
                    last_layer_reg <= speed_reg;
                end
            end
        end
    end

    // Working values for the current average.
    always_ff @(posedge aclk) begin
        if (cmd.avg_start) begin
            avg_sum_reg <= sum_total;
        end
        if (cmd.avg_load) begin
            pot_reg <= (chan_reg == pasc_pkg::CH_LAYER) ? layer_mix : PW'(avg_q);
        end
        if (cmd.trivial_load) begin
            speed_reg <= map_zero ? '0 : full_scale_reg;
        end else if (cmd.map_load) begin
            speed_reg <= div_quo[FW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reel_speed_reg    <= reel_speed_reg;
            out_layer_speed_reg   <= speed_reg;
            out_reel_changed_reg  <= reel_chg;
            out_layer_changed_reg <= layer_chg;
        end
    end

    always_comb begin
        status.sample_last = (s_req_type == pasc_pkg::REQ_SAMPLE) && sel_last;
        status.is_layer    = (chan_reg == pasc_pkg::CH_LAYER);
        status.map_trivial = map_zero || (pot_reg >= POT_MAX) || (map_low >= ADC_MAX_V);
        status.div_done    = div_done;
    end

    assign m_reel_speed    = out_reel_speed_reg;
    assign m_layer_speed   = out_layer_speed_reg;
    assign m_reel_changed  = out_reel_changed_reg;
    assign m_layer_changed = out_layer_changed_reg;

endmodule

`default_nettype wire

/* sv/pasc_ctrl.sv */
// Controller state machine that sequences averaging, mapping and result delivery.
`default_nettype none

module pasc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire pasc_pkg::status_t   status,
    output pasc_pkg::cmd_t           cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_AVG   = 6'b000010,
        S_MAP   = 6'b000100,
        S_MAPW  = 6'b001000,
        S_STORE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.accept    = s_valid;
                cmd.avg_start = s_valid && status.sample_last;
                if (s_valid && status.sample_last) begin
                    state_next = S_AVG;
                end
            end
            S_AVG: begin
                cmd.avg_load = 1'b1;
                state_next   = S_MAP;
            end
            S_MAP: begin
                if (status.map_trivial) begin
                    cmd.trivial_load = 1'b1;
                    state_next       = S_STORE;
                end else begin
                    cmd.map_start = 1'b1;
                    state_next    = S_MAPW;
                end
            end
            S_MAPW: begin
                if (status.div_done) begin
                    cmd.map_load = 1'b1;
                    state_next   = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = status.is_layer ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when taken.
    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // The divider only finishes while the controller waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_MAPW))
        else $error("divider finished outside a wait state");

    // A new result never overwrites one that has not been taken.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // The controller leaves idle only on an accepted transaction.
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !s_valid) |=> state_reg == S_IDLE)
        else $error("left idle without a transaction");

endmodule

`default_nettype wire

/* tb/sv/pot_average_scale_change_detect_core_tb.sv */
// Self-checking testbench for the potentiometer averaging, scaling and change detection core.
module pot_average_scale_change_detect_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLES          = pasc_pkg::SAMPLES_DEFAULT;
    localparam int TICK_CEILING     = 65535;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LONG_HOLD        = 400;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_ITEMS     = 1050;
    localparam int QUIET_ITEMS      = 120;
    localparam int PHASE_ITEMS      = 150;

    // One speed report as it leaves the block.
    typedef struct packed {
        logic [pasc_pkg::FS_W-1:0] reel_speed;
        logic [pasc_pkg::FS_W-1:0] layer_speed;
        logic                      reel_changed;
        logic                      layer_changed;
    } speed_report_t;

    // One row of directed stimulus: a request repeated reps times.
    typedef struct packed {
        logic                          req;
        logic                          ch;
        logic [pasc_pkg::ADC_BITS-1:0] smp;
        int                            reps;
        logic                          typed;
        speed_report_t                 want;
    } stim_row_t;

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic [pasc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [pasc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            s_valid      = 1'b0;
    logic                            s_req_type   = pasc_pkg::REQ_SAMPLE;
    logic                            s_channel    = pasc_pkg::CH_REEL;
    logic [pasc_pkg::ADC_BITS-1:0]   s_adc_sample = '0;
    logic                            m_ready      = 1'b0;
    logic                            s_ready;
    logic                            m_valid;
    logic [pasc_pkg::FS_W-1:0]       m_reel_speed;
    logic [pasc_pkg::FS_W-1:0]       m_layer_speed;
    logic                            m_reel_changed;
    logic                            m_layer_changed;

    // Register shadows.
    logic [pasc_pkg::ADC_BITS-1:0] reel_low_reg   = pasc_pkg::REEL_IN_LOW_RST;
    logic [pasc_pkg::ADC_BITS-1:0] layer_low_reg  = pasc_pkg::LAYER_IN_LOW_RST;
    logic [pasc_pkg::FS_W-1:0]     full_scale_reg = pasc_pkg::FULL_SCALE_RST;
    logic [pasc_pkg::THR_W-1:0]    threshold_reg  = pasc_pkg::CHANGE_THRESHOLD_RST;
    logic [pasc_pkg::GAIN_W-1:0]   gain_reg       = pasc_pkg::LAYER_GAIN_RST;
    logic [pasc_pkg::PERIOD_W-1:0] period_reg     = pasc_pkg::UPDATE_PERIOD_RST;

    // Conditioning state as the block should hold it.
    int unsigned               reel_acc        = 0;
    int unsigned               reel_n          = 0;
    int unsigned               layer_acc       = 0;
    int unsigned               layer_n         = 0;
    int unsigned               reel_mean       = 0;
    logic [pasc_pkg::FS_W-1:0] reel_speed_cur  = '0;
    logic [pasc_pkg::FS_W-1:0] reel_sent       = '0;
    logic [pasc_pkg::FS_W-1:0] layer_sent      = '0;
    int unsigned               ticks_since     = 0;

    speed_report_t pending_reports[$];
    int            mismatches        = 0;
    int            hold_requests     = 0;
    int            cycle_count       = 0;
    bit            quiet             = 1'b0;
    int            reel_level        = 512;
    int            layer_level       = 512;

    // Directed rows, run at reset settings; obvious results are typed in.
    stim_row_t directed_rows [14] = '{
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd0,    16, 1'b1,
          '{13'd0, 13'd0, 1'b0, 1'b0}},
        '{pasc_pkg::REQ_TICK,   pasc_pkg::CH_REEL,  10'd0,    40, 1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_REEL,  10'd1023, 16, 1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd1023, 16, 1'b1,
          '{13'd5000, 13'd5000, 1'b1, 1'b1}},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd1023, 16, 1'b1,
          '{13'd5000, 13'd5000, 1'b0, 1'b0}},
        '{pasc_pkg::REQ_TICK,   pasc_pkg::CH_LAYER, 10'd1023, 40, 1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_REEL,  10'd0,    16, 1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd0,    16, 1'b1,
          '{13'd0, 13'd0, 1'b1, 1'b1}},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_REEL,  10'd700,  16, 1'b0, '0},
        '{pasc_pkg::REQ_TICK,   pasc_pkg::CH_REEL,  10'd0,    39, 1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd555,  16, 1'b0, '0},
        '{pasc_pkg::REQ_TICK,   pasc_pkg::CH_LAYER, 10'd682,  1,  1'b0, '0},
        '{pasc_pkg::REQ_SAMPLE, pasc_pkg::CH_LAYER, 10'd300,  16, 1'b0, '0},
        '{pasc_pkg::REQ_TICK,   pasc_pkg::CH_LAYER, 10'd1023, 1,  1'b0, '0}
    };

    pot_average_scale_change_detect_core #(
        .SAMPLES_PER_AVERAGE (SAMPLES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_channel       (s_channel),
        .s_adc_sample    (s_adc_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reel_speed    (m_reel_speed),
        .m_layer_speed   (m_layer_speed),
        .m_reel_changed  (m_reel_changed),
        .m_layer_changed (m_layer_changed)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Linear map of an average onto 0 .. full scale, clamped at both ends.
    function automatic logic [pasc_pkg::FS_W-1:0] scale_to_speed(input int unsigned avg,
                                                                 input int unsigned low);
        int unsigned fs;
        fs = full_scale_reg;
        if (avg <= low) return '0;
        if (avg >= pasc_pkg::ADC_MAX || low >= pasc_pkg::ADC_MAX) return pasc_pkg::FS_W'(fs);
        return pasc_pkg::FS_W'(((avg - low) * fs) / (pasc_pkg::ADC_MAX - low));
    endfunction

    function automatic bit moved_beyond_threshold(input logic [pasc_pkg::FS_W-1:0] now_val,
                                                  input logic [pasc_pkg::FS_W-1:0] sent_val);
        int unsigned gap;
        gap = (now_val > sent_val) ? now_val - sent_val : sent_val - now_val;
        return gap > threshold_reg;
    endfunction

    // Advances the conditioning state by one request; returns 1 when a report is due.
    function automatic bit condition_request(input logic req, input logic ch,
                                             input logic [pasc_pkg::ADC_BITS-1:0] smp,
                                             output speed_report_t rep);
        int unsigned               pot;
        logic [pasc_pkg::FS_W-1:0] layer_speed;
        rep = '0;
        if (req == pasc_pkg::REQ_TICK) begin
            if (ticks_since < TICK_CEILING) ticks_since++;
            return 1'b0;
        end
        if (ch == pasc_pkg::CH_REEL) begin
            reel_acc += smp;
            reel_n++;
            if (reel_n == SAMPLES) begin
                reel_mean      = reel_acc / SAMPLES;
                reel_speed_cur = scale_to_speed(reel_mean, reel_low_reg);
                reel_acc       = 0;
                reel_n         = 0;
            end
            return 1'b0;
        end
        layer_acc += smp;
        layer_n++;
        if (layer_n < SAMPLES) return 1'b0;
        pot         = layer_acc / SAMPLES + gain_reg * reel_mean;
        layer_acc   = 0;
        layer_n     = 0;
        layer_speed = scale_to_speed(pot, layer_low_reg);
        // Change flags only once the update period has run out.
        if (ticks_since >= period_reg) begin
            if (moved_beyond_threshold(reel_speed_cur, reel_sent)) begin
                rep.reel_changed = 1'b1;
                reel_sent        = reel_speed_cur;
            end
            if (moved_beyond_threshold(layer_speed, layer_sent)) begin
                rep.layer_changed = 1'b1;
                layer_sent        = layer_speed;
            end
            ticks_since = 0;
        end
        rep.reel_speed  = reel_speed_cur;
        rep.layer_speed = layer_speed;
        return 1'b1;
    endfunction

    // Picks an end point now and then, otherwise a value in between.
    function automatic int unsigned spread(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Samples wander around a slowly moving level, with outliers and extremes.
    function automatic logic [pasc_pkg::ADC_BITS-1:0] draw_sample(input logic ch);
        int level;
        int v;
        if ($urandom_range(0, 39) == 0) begin
            if (ch == pasc_pkg::CH_REEL) reel_level = $urandom_range(0, pasc_pkg::ADC_MAX);
            else layer_level = $urandom_range(0, pasc_pkg::ADC_MAX);
        end
        level = (ch == pasc_pkg::CH_REEL) ? reel_level : layer_level;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, pasc_pkg::ADC_MAX);
            1: v = $urandom_range(0, 1) ? pasc_pkg::ADC_MAX : 0;
            default: v = level + int'($urandom_range(0, 8)) - 4;
        endcase
        if (v < 0) v = 0;
        if (v > pasc_pkg::ADC_MAX) v = pasc_pkg::ADC_MAX;
        return pasc_pkg::ADC_BITS'(v);
    endfunction

    // Offers one request and waits for its transaction; predicts what it causes.
    task automatic send_item(input logic req, input logic ch,
                             input logic [pasc_pkg::ADC_BITS-1:0] smp,
                             input logic typed, input speed_report_t typed_val);
        speed_report_t rep;
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_channel    <= ch;
        s_adc_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        if (condition_request(req, ch, smp, rep)) begin
            pending_reports.push_back(typed ? typed_val : rep);
        end
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [pasc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= pasc_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        case (idx)
            pasc_pkg::REG_REEL_IN_LOW:      reel_low_reg   = pasc_pkg::ADC_BITS'(value);
            pasc_pkg::REG_LAYER_IN_LOW:     layer_low_reg  = pasc_pkg::ADC_BITS'(value);
            pasc_pkg::REG_FULL_SCALE:       full_scale_reg = pasc_pkg::FS_W'(value);
            pasc_pkg::REG_CHANGE_THRESHOLD: threshold_reg  = pasc_pkg::THR_W'(value);
            pasc_pkg::REG_LAYER_GAIN:       gain_reg       = pasc_pkg::GAIN_W'(value);
            pasc_pkg::REG_UPDATE_PERIOD:    period_reg     = pasc_pkg::PERIOD_W'(value);
            default: ;
        endcase
    endtask

    // Drains the block, lets a pending average finish, then writes every register.
    task automatic apply_settings(input int unsigned reel_low, input int unsigned layer_low,
                                  input int unsigned fs, input int unsigned thr,
                                  input int unsigned gain, input int unsigned period);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(pasc_pkg::REG_REEL_IN_LOW, reel_low);
        write_reg(pasc_pkg::REG_LAYER_IN_LOW, layer_low);
        write_reg(pasc_pkg::REG_FULL_SCALE, fs);
        write_reg(pasc_pkg::REG_CHANGE_THRESHOLD, thr);
        write_reg(pasc_pkg::REG_LAYER_GAIN, gain);
        write_reg(pasc_pkg::REG_UPDATE_PERIOD, period);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_phase_settings(input int phase);
        case (phase)
            0: apply_settings(0, 0, 1, 0, 0, 1);
            1: apply_settings(1022, 1022, 8191, 8191, 15, 65535);
            2: apply_settings(pasc_pkg::ADC_MAX, pasc_pkg::ADC_MAX, 8191, 0, 3, 0);
            3: apply_settings($urandom_range(0, 1022), $urandom_range(0, 1022), 0, 0,
                              $urandom_range(0, 15), 0);
            default: apply_settings(spread(0, 1022), spread(0, 1022), spread(1, 8191),
                                    ($urandom_range(0, 3) == 0) ? spread(0, 8191)
                                                                : $urandom_range(0, 120),
                                    spread(0, 15),
                                    ($urandom_range(0, 3) == 0) ? spread(1, 65535)
                                                                : $urandom_range(1, 24));
        endcase
    endtask

    // Random mix of ticks, reel samples and layer samples.
    task automatic run_random_items(input int n_items);
        int   pick;
        logic ch;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            ch   = (pick < 55) ? pasc_pkg::CH_REEL : pasc_pkg::CH_LAYER;
            if (pick < 25) begin
                send_item(pasc_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
                          pasc_pkg::ADC_BITS'($urandom_range(0, pasc_pkg::ADC_MAX)),
                          1'b0, '0);
            end else begin
                send_item(pasc_pkg::REQ_SAMPLE, ch, draw_sample(ch), 1'b0, '0);
            end
            maybe_pause();
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int holds_served;
        holds_served = 0;
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest expected report.
    always @(posedge aclk) begin
        speed_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result transaction: reel_speed %0d layer_speed %0d",
                       m_reel_speed, m_layer_speed);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (m_reel_speed !== want.reel_speed) begin
                    $error("reel_speed: expected %0d, actual %0d",
                           want.reel_speed, m_reel_speed);
                    mismatches++;
                end
                if (m_layer_speed !== want.layer_speed) begin
                    $error("layer_speed: expected %0d, actual %0d",
                           want.layer_speed, m_layer_speed);
                    mismatches++;
                end
                if (m_reel_changed !== want.reel_changed) begin
                    $error("reel_changed: expected %0d, actual %0d",
                           want.reel_changed, m_reel_changed);
                    mismatches++;
                end
                if (m_layer_changed !== want.layer_changed) begin
                    $error("layer_changed: expected %0d, actual %0d",
                           want.layer_changed, m_layer_changed);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pot_average_scale_change_detect_core_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int   phase;
        int   random_sent;
        phase       = 0;
        random_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table at reset settings.
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_item(directed_rows[r].req, directed_rows[r].ch, directed_rows[r].smp,
                          directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                          directed_rows[r].want);
                maybe_pause();
            end
        end

        // Random phases, each under its own register settings.
        while (random_sent < RANDOM_ITEMS) begin
            apply_phase_settings(phase);
            if (phase == 4) hold_requests++;
            run_random_items(PHASE_ITEMS);
            random_sent += PHASE_ITEMS;
            phase++;
        end

        // Closing stretch without any idling.
        quiet = 1'b1;
        apply_phase_settings(phase);
        run_random_items(QUIET_ITEMS);
        s_valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("pot_average_scale_change_detect_core_tb OK");
        end else begin
            $display("pot_average_scale_change_detect_core_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/pasc_pkg.sv
sv/pasc_div.sv
sv/pasc_datapath.sv
sv/pasc_ctrl.sv
sv/pot_average_scale_change_detect_core.sv
tb/sv/pot_average_scale_change_detect_core_tb.sv
